// ----- design/sta_pkg.sv -----
// ----------------------------------------------------------------------------
// sta_pkg
// Shared types and constants for the server task assigner.
// ----------------------------------------------------------------------------
package sta_pkg;

  localparam int MaxServersDef = 256;
  localparam int WeightBitsDef = 20;
  localparam int TimeBitsDef   = 48;

  localparam logic       CMD_ADD    = 1'b0;
  localparam logic       CMD_TASK   = 1'b1;
  localparam logic [1:0] ST_ASSIGN  = 2'd0;
  localparam logic [1:0] ST_ADDED   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_NOSRV   = 2'd3;

  typedef struct packed {
    logic        cmd;
    logic [19:0] server_weight;
    logic [19:0] task_duration;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  server_index;
    logic [47:0] start_time;
    logic [1:0]  status;
  } out_item_t;

endpackage

// ----- design/sta_cmd_queue.sv -----
// ----------------------------------------------------------------------------
// sta_cmd_queue
// Short queue that decouples the front end from the scheduling engine.
// ----------------------------------------------------------------------------
module sta_cmd_queue #(
  parameter int Depth = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  sta_pkg::in_item_t wr_data,
  output logic              full,
  input  logic              rd_en,
  output sta_pkg::in_item_t rd_data,
  output logic              empty
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  sta_pkg::in_item_t mem [Depth];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full    = (cnt_r == (AW+1)'(Depth));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en && !full) begin
      mem[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en && !full) begin
        wp_r <= (wp_r == AW'(Depth-1)) ? '0 : wp_r + 1'b1;
      end
      if (rd_en && !empty) begin
        rp_r <= (rp_r == AW'(Depth-1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(wr_en && !full) - (AW+1)'(rd_en && !empty);
    end
  end

endmodule

// ----- design/sta_heap.sv -----
// ----------------------------------------------------------------------------
// sta_heap
// Binary min-heap in a memory with sequential push and pop-root sifting.
// Key is compared as an unsigned number; the whole word is the key.
// ----------------------------------------------------------------------------
module sta_heap #(
  parameter int Depth = 256,
  parameter int KeyW  = 28
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  logic            pop,
  input  logic [KeyW-1:0] din,
  output logic [KeyW-1:0] top,
  output logic            busy,
  output logic [$clog2(Depth+1)-1:0] count
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth+1);

  typedef enum logic [2:0] {
    S_IDLE, S_UP_RD, S_UP_CMP, S_DN_LD, S_DN_V, S_DN_B, S_DN_A, S_DN_CMP
  } state_t;

  logic [KeyW-1:0] mem [Depth];
  state_t          state_r;
  logic [CW-1:0]   cnt_r, n_r;
  logic [CW-1:0]   i_r;
  logic [KeyW-1:0] v_r, top_r, rd_r, rda_r;
  logic [AW-1:0]   ra_r;
  logic            we;
  logic [AW-1:0]   wa;
  logic [KeyW-1:0] wd;
  logic [CW:0]     c1, c2, cn;
  logic [CW-1:0]   par;
  logic            pick2, move;
  logic [KeyW-1:0] hc;

  assign count = cnt_r;
  assign top   = top_r;
  assign busy  = (state_r != S_IDLE);
  assign par   = (i_r - 1'b1) >> 1;
  assign c1    = {i_r, 1'b1};
  assign c2    = c1 + 1'b1;
  assign pick2 = (c2 < {1'b0, n_r}) && (rd_r < rda_r);
  assign hc    = pick2 ? rd_r : rda_r;
  assign cn    = pick2 ? c2 : c1;
  assign move  = (c1 < {1'b0, n_r}) && (hc < v_r);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_r <= mem[ra_r];
  end

  always_comb begin
    we = 1'b0;
    wa = i_r[AW-1:0];
    wd = v_r;
    case (state_r)
      S_UP_CMP: begin
        we = 1'b1;
        if (i_r != '0 && v_r < rd_r) begin
          wd = rd_r;
        end
      end
      S_DN_CMP: begin
        we = 1'b1;
        if (move) begin
          wd = hc;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (push && cnt_r < CW'(Depth)) begin
            v_r     <= din;
            i_r     <= cnt_r;
            cnt_r   <= cnt_r + 1'b1;
            ra_r    <= AW'((cnt_r - 1'b1) >> 1);
            state_r <= S_UP_RD;
          end else if (pop && cnt_r != '0) begin
            n_r     <= cnt_r - 1'b1;
            cnt_r   <= cnt_r - 1'b1;
            i_r     <= '0;
            ra_r    <= AW'(cnt_r - 1'b1);
            state_r <= S_DN_LD;
          end
        end
        S_UP_RD: begin
          state_r <= S_UP_CMP;
        end
        S_UP_CMP: begin
          if (i_r != '0 && v_r < rd_r) begin
            i_r     <= par;
            ra_r    <= AW'((par - 1'b1) >> 1);
            state_r <= S_UP_RD;
          end else begin
            if (i_r == '0) begin
              top_r <= v_r;
            end
            state_r <= S_IDLE;
          end
        end
        S_DN_LD: begin
          if (n_r == '0) begin
            state_r <= S_IDLE;
          end else begin
            ra_r    <= AW'(c1);
            state_r <= S_DN_V;
          end
        end
        S_DN_V: begin
          v_r     <= rd_r;
          ra_r    <= AW'(c2);
          state_r <= S_DN_A;
        end
        S_DN_B: begin
          ra_r    <= AW'(c2);
          state_r <= S_DN_A;
        end
        S_DN_A: begin
          rda_r   <= rd_r;
          state_r <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (i_r == '0) begin
            top_r <= wd;
          end
          if (move) begin
            i_r     <= CW'(cn);
            ra_r    <= AW'({cn, 1'b1});
            state_r <= S_DN_B;
          end else begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- design/sta_engine.sv -----
// ----------------------------------------------------------------------------
// sta_engine
// Back end: runs add and task transactions against the idle and busy heaps.
// ----------------------------------------------------------------------------
module sta_engine #(
  parameter int MaxServers = 256,
  parameter int WeightBits = 20,
  parameter int TimeBits   = 48
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  sta_pkg::in_item_t  q_data,
  output logic               q_pop,
  input  logic               pop,
  output logic               empty,
  output sta_pkg::out_item_t res
);

  localparam int IW = (MaxServers > 1) ? $clog2(MaxServers) : 1;
  localparam int CW = $clog2(MaxServers+1);
  localparam int IK = WeightBits + IW;
  localparam int BK = TimeBits + IK;
  localparam logic [TimeBits-1:0] TMax = '1;

  typedef enum logic [2:0] {
    E_IDLE, E_DECIDE, E_REL_CHK, E_REL_WAIT, E_TAKE, E_PUT, E_OUT
  } state_t;

  state_t            state_r;
  sta_pkg::in_item_t it_r;
  logic [CW-1:0]     added_r;
  logic [TimeBits-1:0] cur_r, seen_r, t_r;
  logic [IK-1:0]     sel_r;
  logic              res_v_r;
  sta_pkg::out_item_t res_r;

  logic ih_push, ih_pop, ih_busy, bh_push, bh_pop, bh_busy;
  logic [IK-1:0] ih_din, ih_top;
  logic [BK-1:0] bh_din, bh_top;
  logic [CW-1:0] ih_cnt, bh_cnt;
  logic [TimeBits:0] fin_w;
  logic          rel;

  sta_heap #(.Depth(MaxServers), .KeyW(IK)) u_idle (
    .clk, .rst_n, .push(ih_push), .pop(ih_pop), .din(ih_din),
    .top(ih_top), .busy(ih_busy), .count(ih_cnt)
  );
  sta_heap #(.Depth(MaxServers), .KeyW(BK)) u_busy (
    .clk, .rst_n, .push(bh_push), .pop(bh_pop), .din(bh_din),
    .top(bh_top), .busy(bh_busy), .count(bh_cnt)
  );

  assign empty = !res_v_r;
  assign res   = res_r;
  assign q_pop = (state_r == E_IDLE) && !q_empty && !res_v_r;
  assign fin_w = {1'b0, t_r} + (TimeBits+1)'(it_r.task_duration);
  assign rel   = (bh_cnt != '0) && (bh_top[BK-1 -: TimeBits] <= t_r);

  always_comb begin
    ih_push = 1'b0;
    ih_pop  = 1'b0;
    ih_din  = {WeightBits'(it_r.server_weight), added_r[IW-1:0]};
    bh_push = 1'b0;
    bh_pop  = 1'b0;
    bh_din  = {(fin_w[TimeBits] ? TMax : fin_w[TimeBits-1:0]), sel_r};
    case (state_r)
      E_DECIDE: ih_push = (it_r.cmd == sta_pkg::CMD_ADD) && (added_r < CW'(MaxServers));
      E_REL_CHK: begin
        if (rel) begin
          bh_pop  = 1'b1;
          ih_push = 1'b1;
          ih_din  = bh_top[IK-1:0];
        end
      end
      E_TAKE:  ih_pop = 1'b1;
      E_PUT:   bh_push = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
      res_v_r <= 1'b0;
      added_r <= '0;
      cur_r   <= '0;
      seen_r  <= '0;
    end else begin
      if (pop && res_v_r) begin
        res_v_r <= 1'b0;
      end
      case (state_r)
        E_IDLE: begin
          if (q_pop) begin
            it_r    <= q_data;
            state_r <= E_DECIDE;
          end
        end
        E_DECIDE: begin
          if (it_r.cmd == sta_pkg::CMD_ADD) begin
            res_r.start_time <= '0;
            if (added_r < CW'(MaxServers)) begin
              res_r.server_index <= 8'(added_r);
              res_r.status       <= sta_pkg::ST_ADDED;
              added_r            <= added_r + 1'b1;
            end else begin
              res_r.server_index <= '0;
              res_r.status       <= sta_pkg::ST_FULL;
            end
            state_r <= E_OUT;
          end else begin
            if (seen_r != TMax) begin
              seen_r <= seen_r + 1'b1;
            end
            if (ih_cnt == '0 && bh_cnt == '0) begin
              res_r.server_index <= '0;
              res_r.start_time   <= '0;
              res_r.status       <= sta_pkg::ST_NOSRV;
              state_r            <= E_OUT;
            end else begin
              if (ih_cnt != '0) begin
                t_r <= (cur_r > seen_r) ? cur_r : seen_r;
              end else begin
                t_r <= bh_top[BK-1 -: TimeBits];
              end
              state_r <= E_REL_CHK;
            end
          end
        end
        E_REL_CHK: begin
          if (rel) begin
            state_r <= E_REL_WAIT;
          end else begin
            cur_r   <= t_r;
            state_r <= E_TAKE;
          end
        end
        E_REL_WAIT: begin
          if (!ih_busy && !bh_busy) begin
            state_r <= E_REL_CHK;
          end
        end
        E_TAKE: begin
          sel_r   <= ih_top;
          state_r <= E_PUT;
        end
        E_PUT: begin
          res_r.server_index <= 8'(sel_r[IW-1:0]);
          res_r.start_time   <= 48'(t_r);
          res_r.status       <= sta_pkg::ST_ASSIGN;
          state_r            <= E_OUT;
        end
        E_OUT: begin
          if (!ih_busy && !bh_busy) begin
            res_v_r <= 1'b1;
            state_r <= E_IDLE;
          end
        end
        default: state_r <= E_IDLE;
      endcase
    end
  end

endmodule

// ----- design/server_task_assigner_unit.sv -----
// ----------------------------------------------------------------------------
// server_task_assigner_unit
// Assigns tasks to weighted servers with an idle heap and a busy heap.
// ----------------------------------------------------------------------------
// Input transactions are pushed with push while full is low; each is an
// add-server or submit-task command. A two-entry queue holds commands while
// the engine works. Each command yields exactly one result transaction, read
// with pop while empty is low; one result is held at a time.
// An add finishes once its push has sifted up the idle heap. A task waits
// for its pop from the idle heap and its push into the busy heap, and also for
// every busy server that it returns to the idle heap. The sifts through the
// heap memories are sequential: going up, each level has a read state and a
// compare state; going down, it loads both children and then compares.
// Synchronous reset empties both heaps and clears time and counters.
// While the result waits unread, the engine holds and the queue fills.
// ----------------------------------------------------------------------------
module server_task_assigner_unit #(
  parameter int MaxServers = sta_pkg::MaxServersDef,
  parameter int WeightBits = sta_pkg::WeightBitsDef,
  parameter int TimeBits   = sta_pkg::TimeBitsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  sta_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output sta_pkg::out_item_t out_item
);

  logic              q_empty, q_pop;
  sta_pkg::in_item_t q_data;

  sta_cmd_queue #(.Depth(2)) u_q (
    .clk, .rst_n, .wr_en(push), .wr_data(in_item), .full,
    .rd_en(q_pop), .rd_data(q_data), .empty(q_empty)
  );

  sta_engine #(.MaxServers(MaxServers), .WeightBits(WeightBits),
               .TimeBits(TimeBits)) u_eng (
    .clk, .rst_n, .q_empty, .q_data, .q_pop, .pop, .empty, .res(out_item)
  );

  a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("queue read while empty");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> !empty) else $error("result dropped");

endmodule

// ----- sim/server_task_assigner_unit_test.sv -----
// ----------------------------------------------------------------------------
// server_task_assigner_unit_test
// Self-checking testbench for the server task assigner. A directed table of
// add and task transactions is followed by random traffic; every result is
// checked with its table entry if known, else with a two-heap scheduler model.
// ----------------------------------------------------------------------------
module server_task_assigner_unit_test;

  localparam int NumServers = 256;
  localparam logic [47:0] TimeMax = 48'hFFFF_FFFF_FFFF;

  typedef struct {
    logic [47:0] finish;
    logic [19:0] weight;
    logic [8:0]  index;
  } slot_t;

  typedef struct {
    sta_pkg::in_item_t  item;
    logic               known;
    sta_pkg::out_item_t result;
  } row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      push = 1'b0;
  logic      pop = 1'b0;
  logic      full;
  logic      empty;
  sta_pkg::in_item_t  in_item = '0;
  sta_pkg::out_item_t out_item;

  slot_t       idle_q[NumServers];
  slot_t       busy_q[NumServers];
  int          idle_n;
  int          busy_n;
  int          added_n;
  logic [47:0] now_time;
  logic [47:0] task_count;
  sta_pkg::out_item_t pending_results[$];
  int          errors = 0;
  bit          feeding_done = 1'b0;
  row_t        rows[$];

  server_task_assigner_unit DUT (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item)
  );

  always #1 clk = ~clk;

  function automatic bit slot_lt(slot_t a, slot_t b);
    if (a.finish != b.finish) return a.finish < b.finish;
    if (a.weight != b.weight) return a.weight < b.weight;
    return a.index < b.index;
  endfunction

  task automatic heap_insert(ref slot_t h[NumServers], ref int n, input slot_t v);
    int i;
    int p;
    i = n;
    if (i >= NumServers) return;
    n++;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!slot_lt(v, h[p])) break;
      h[i] = h[p];
      i = p;
    end
    h[i] = v;
  endtask

  task automatic heap_take(ref slot_t h[NumServers], ref int n, output slot_t top);
    slot_t last;
    int i;
    int c;
    top = h[0];
    if (n == 0) return;
    n--;
    last = h[n];
    i = 0;
    forever begin
      c = 2 * i + 1;
      if (c >= n) break;
      if (c + 1 < n && slot_lt(h[c + 1], h[c])) c++;
      if (!slot_lt(h[c], last)) break;
      h[i] = h[c];
      i = c;
    end
    if (n > 0) h[i] = last;
  endtask

  task automatic schedule_step(input sta_pkg::in_item_t it, output sta_pkg::out_item_t r);
    slot_t       s;
    logic [47:0] arrival;
    logic [47:0] t;
    logic [48:0] fin;
    r = '0;
    if (it.cmd == sta_pkg::CMD_ADD) begin
      if (added_n >= NumServers) begin
        r.status = sta_pkg::ST_FULL;
        return;
      end
      s.finish = '0;
      s.weight = it.server_weight;
      s.index = added_n[8:0];
      heap_insert(idle_q, idle_n, s);
      added_n++;
      r.server_index = s.index[7:0];
      r.status = sta_pkg::ST_ADDED;
      return;
    end
    arrival = task_count;
    if (task_count < TimeMax) task_count++;
    if (idle_n == 0 && busy_n == 0) begin
      r.status = sta_pkg::ST_NOSRV;
      return;
    end
    if (idle_n > 0) t = (now_time > arrival) ? now_time : arrival;
    else t = busy_q[0].finish;
    while (busy_n > 0 && busy_q[0].finish <= t) begin
      heap_take(busy_q, busy_n, s);
      s.finish = '0;
      heap_insert(idle_q, idle_n, s);
    end
    now_time = t;
    heap_take(idle_q, idle_n, s);
    fin = {1'b0, t} + {29'd0, it.task_duration};
    s.finish = (fin > {1'b0, TimeMax}) ? TimeMax : fin[47:0];
    heap_insert(busy_q, busy_n, s);
    r.server_index = s.index[7:0];
    r.start_time = t;
    r.status = sta_pkg::ST_ASSIGN;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  task automatic send_item(input sta_pkg::in_item_t it, input logic known,
                           input sta_pkg::out_item_t want);
    sta_pkg::out_item_t r;
    int g;
    g = gap_len();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(negedge clk);
    end
    push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    schedule_step(it, r);
    if (known) pending_results.push_back(want);
    else pending_results.push_back(r);
    @(negedge clk);
  endtask

  function automatic row_t mk(logic cmd, logic [19:0] w, logic [19:0] d,
                              logic known = 1'b0, logic [7:0] idx = '0,
                              logic [47:0] st = '0,
                              logic [1:0] status = sta_pkg::ST_ASSIGN);
    row_t r;
    r.item.cmd = cmd;
    r.item.server_weight = w;
    r.item.task_duration = d;
    r.known = known;
    r.result.server_index = idx;
    r.result.start_time = st;
    r.result.status = status;
    return r;
  endfunction

  always @(posedge clk) begin
    sta_pkg::out_item_t want;
    if (rst_n && pop && !empty) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_item), 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_item.server_index != want.server_index)
          report_mismatch("server_index", 64'(out_item.server_index),
                          64'(want.server_index));
        if (out_item.start_time != want.start_time)
          report_mismatch("start_time", 64'(out_item.start_time), 64'(want.start_time));
        if (out_item.status != want.status)
          report_mismatch("status", 64'(out_item.status), 64'(want.status));
      end
    end
  end

  initial begin
    int g;
    @(negedge clk);
    while (1) begin
      g = gap_len();
      if (g > 0 && $urandom_range(0, 3) != 0) begin
        pop <= 1'b0;
        repeat (g) @(negedge clk);
      end
      pop <= 1'b1;
      @(negedge clk);
    end
  end

  initial begin
    sta_pkg::in_item_t  it;
    sta_pkg::out_item_t none;
    sta_pkg::out_item_t full_res;
    int        n;
    int        phase;
    none = '0;
    full_res = '0;
    full_res.status = sta_pkg::ST_FULL;
    idle_n = 0;
    busy_n = 0;
    added_n = 0;
    now_time = '0;
    task_count = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    rows.push_back(mk(sta_pkg::CMD_TASK, 20'hFFFFF, 20'hFFFFF, 1'b1, 8'd0, 48'd0,
                      sta_pkg::ST_NOSRV));
    rows.push_back(mk(sta_pkg::CMD_ADD, 20'hFFFFF, 20'h00000, 1'b1, 8'd0, 48'd0,
                      sta_pkg::ST_ADDED));
    rows.push_back(mk(sta_pkg::CMD_ADD, 20'h00000, 20'hFFFFF, 1'b1, 8'd1, 48'd0,
                      sta_pkg::ST_ADDED));
    rows.push_back(mk(sta_pkg::CMD_ADD, 20'h00000, 20'h00000, 1'b1, 8'd2, 48'd0,
                      sta_pkg::ST_ADDED));
    rows.push_back(mk(sta_pkg::CMD_TASK, 20'h00000, 20'hFFFFF));
    rows.push_back(mk(sta_pkg::CMD_TASK, 20'h00000, 20'h00000));
    rows.push_back(mk(sta_pkg::CMD_TASK, 20'h00000, 20'h00005));
    rows.push_back(mk(sta_pkg::CMD_TASK, 20'h00000, 20'h00001));
    rows.push_back(mk(sta_pkg::CMD_TASK, 20'h00000, 20'hFFFFF));
    rows.push_back(mk(sta_pkg::CMD_TASK, 20'h00000, 20'h00003));
    rows.push_back(mk(sta_pkg::CMD_TASK, 20'h00000, 20'h00003));
    rows.push_back(mk(sta_pkg::CMD_TASK, 20'h00000, 20'hAAAAA));
    rows.push_back(mk(sta_pkg::CMD_TASK, 20'h00000, 20'h55555));
    rows.push_back(mk(sta_pkg::CMD_TASK, 20'h00000, 20'h00000));
    foreach (rows[i]) send_item(rows[i].item, rows[i].known, rows[i].result);

    for (n = 0; n < 360; n++) begin
      phase = n / 90;
      it.cmd = ($urandom_range(0, 99) < (phase == 3 ? 60 : 12)) ? sta_pkg::CMD_ADD
                                                                : sta_pkg::CMD_TASK;
      case ($urandom_range(0, 3))
        0: it.server_weight = 20'($urandom_range(0, 3));
        1: it.server_weight = 20'($urandom());
        default: it.server_weight = 20'($urandom_range(0, 15)) | 20'hFFFF0;
      endcase
      case ($urandom_range(0, 5))
        0: it.task_duration = 20'hFFFFF - 20'($urandom_range(0, 3));
        1: it.task_duration = 20'($urandom());
        default: it.task_duration = 20'($urandom_range(0, phase == 1 ? 3 : 40));
      endcase
      send_item(it, 1'b0, none);
    end
    while (added_n < NumServers) begin
      it = '0;
      it.cmd = sta_pkg::CMD_ADD;
      it.server_weight = 20'($urandom());
      send_item(it, 1'b0, none);
    end
    for (n = 0; n < 2; n++) begin
      it = '0;
      it.cmd = sta_pkg::CMD_ADD;
      it.server_weight = 20'($urandom());
      send_item(it, 1'b1, full_res);
    end
    for (n = 0; n < 20; n++) begin
      it.cmd = sta_pkg::CMD_TASK;
      it.server_weight = 20'($urandom());
      it.task_duration = 20'($urandom());
      send_item(it, 1'b0, none);
    end
    push <= 1'b0;
    feeding_done = 1'b1;
  end

  initial begin
    wait (feeding_done);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("[server_task_assigner_unit] OK");
    end else begin
      $display("[server_task_assigner_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[server_task_assigner_unit] ERROR");
    $finish;
  end

endmodule

// ----- server_task_assigner_unit.f -----
design/sta_pkg.sv
design/sta_cmd_queue.sv
design/sta_heap.sv
design/sta_engine.sv
design/server_task_assigner_unit.sv
sim/server_task_assigner_unit_test.sv
